>>> rtl/brs_pkg.sv
// Package for the byte ring sync search block: status codes, register indexes,
// field widths, controller states and the command/status structs.
// Used by brs_ctrl, brs_dpath and byte_ring_sync_search; depends on nothing.
package brs_pkg;

	// Default geometry.
	localparam int DEF_BUFFER_DEPTH = 256;
	localparam int DEF_MAX_PATTERN  = 8;

	// Fixed field widths.
	localparam int BYTE_W     = 8;
	localparam int PATTERN_W  = 64;
	localparam int PLEN_W     = 4;
	localparam int STATUS_W   = 3;
	localparam int POS_W      = 8;
	localparam int FILL_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int OUT_DATA_W = 24;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;
	localparam logic [PATTERN_W-1:0] PATTERN_RESET      = 64'h0000_0000_0000_6405;
	localparam logic [PLEN_W-1:0]    LENGTH_RESET       = 4'd2;

	// Item kinds carried on s_tuser.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_SYNC  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED    = 3'd0,
		ST_FULL      = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_LEN   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_item;  // store the accepted byte and load its result
		logic bad_item;    // load a bad-length result
		logic scan_start;  // clear the scan counters
		logic scan_run;    // stream bytes out of the store
		logic scan_close;  // register the pointer skip
		logic commit;      // move the pointers and load the sync result
	} brs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad_len;     // pattern length outside the supported range
		logic hit;         // window holds a full pattern match
		logic drained;     // every held byte has reached the window
	} brs_stat_t;

	// Byte j of the pattern register.
	function automatic logic [BYTE_W-1:0] pat_byte(input logic [PATTERN_W-1:0] pat,
			input logic [2:0] j);
		return pat[{j, 3'b000} +: BYTE_W];
	endfunction

endpackage

>>> rtl/brs_ctrl.sv
// Controller state machine of the byte ring sync search block.
// Sequences writes, bad-length replies and sync scans; owns the output valid.
// Depends on brs_pkg.
module brs_ctrl
	import brs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      mode,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  brs_stat_t stat,
	output brs_cmd_t  cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_load;
	logic   accept;

	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign out_load = cmd.write_item || cmd.bad_item || cmd.commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_WRITE) begin
						cmd.write_item = 1'b1;
					end else if (stat.bad_len) begin
						cmd.bad_item = 1'b1;
					end else begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.hit || stat.drained) begin
					cmd.scan_close = 1'b1;
					state_nxt      = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// The scan result is committed in the cycle right after the scan closes.
	a_close_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_close |=> cmd.commit)
		else $error("scan closed without a commit in the next cycle");

	// A sync result is only loaded into an output register that is free.
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("sync result overwrote a pending result");

	// Only one result source loads the output register in a cycle.
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.write_item, cmd.bad_item, cmd.commit}))
		else $error("more than one result loaded at once");

endmodule

>>> rtl/brs_dpath.sv
// Datapath of the byte ring sync search block: configuration registers, the
// byte store, ring pointers, the scan window and the output register.
// Depends on brs_pkg; commanded by brs_ctrl.
module brs_dpath
	import brs_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int MAX_PATTERN  = DEF_MAX_PATTERN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PATTERN_W-1:0]  cfg_data,
	input  logic [BYTE_W-1:0]     data_byte,
	input  brs_cmd_t              cmd,
	output brs_stat_t             stat,
	output logic [STATUS_W-1:0]   status,
	output logic [POS_W-1:0]      read_position,
	output logic [FILL_W-1:0]     fill_count
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = AW + 1;

	logic [PATTERN_W-1:0] pattern_q;
	logic [PLEN_W-1:0]    plen_q;

	logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
	logic [AW-1:0]     rd_ptr_q, wr_ptr_q;
	logic [CW-1:0]     held_q;

	logic [CW-1:0]     iss_cnt_q, rcv_cnt_q, skip_q;
	logic              vld_s1;
	logic [BYTE_W-1:0] rdata_s1;
	logic [BYTE_W-1:0] win_q [MAX_PATTERN];
	logic              found_q;

	status_t           out_status_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [FILL_W-1:0] out_fill_q;

	logic              full;
	logic              issue;
	logic [AW-1:0]     rd_addr;
	logic              hit_bytes, hit;
	logic              tail_ok;
	logic [PLEN_W-1:0] tail_len;
	logic [AW-1:0]     new_rd;
	logic [CW-1:0]     new_held;

	assign full     = (held_q == CW'(BUFFER_DEPTH));
	assign issue    = cmd.scan_run && (iss_cnt_q < held_q);
	assign rd_addr  = rd_ptr_q + iss_cnt_q[AW-1:0];
	assign new_rd   = rd_ptr_q + skip_q[AW-1:0];
	assign new_held = held_q - skip_q;

	// Newest byte sits in win_q[0]; a match ending there needs
	// win_q[p] to equal pattern byte plen-1-p for every p below plen.
	always_comb begin
		hit_bytes = 1'b1;
		for (int p = 0; p < MAX_PATTERN; p++) begin
			if ((PLEN_W'(p) < plen_q) &&
					(win_q[p] != pat_byte(pattern_q, 3'(plen_q - PLEN_W'(p + 1))))) begin
				hit_bytes = 1'b0;
			end
		end
	end

	assign hit = hit_bytes && (rcv_cnt_q >= CW'(plen_q));

	// Longest held tail, shorter than the pattern, that is a pattern prefix.
	always_comb begin
		tail_len = '0;
		tail_ok  = 1'b0;
		for (int l = 1; l < MAX_PATTERN; l++) begin
			tail_ok = (PLEN_W'(l) < plen_q) && (CW'(l) <= rcv_cnt_q);
			for (int j = 0; j < l; j++) begin
				if (win_q[l - 1 - j] != pattern_q[8 * j +: BYTE_W]) begin
					tail_ok = 1'b0;
				end
			end
			if (tail_ok) begin
				tail_len = PLEN_W'(l);
			end
		end
	end

	assign stat.bad_len = (plen_q == '0) || (plen_q > PLEN_W'(MAX_PATTERN));
	assign stat.hit     = hit;
	assign stat.drained = (rcv_cnt_q == held_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PATTERN_RESET;
			plen_q    <= LENGTH_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_SYNC_PATTERN:   pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: plen_q    <= cfg_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Byte store: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.write_item && !full) begin
			mem[wr_ptr_q] <= data_byte;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Ring pointers and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			held_q    <= '0;
			iss_cnt_q <= '0;
			rcv_cnt_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (cmd.write_item && !full) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
				held_q   <= held_q + CW'(1);
			end
			if (cmd.commit) begin
				rd_ptr_q <= new_rd;
				held_q   <= new_held;
			end
			if (cmd.scan_start) begin
				iss_cnt_q <= '0;
				rcv_cnt_q <= '0;
				vld_s1    <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					iss_cnt_q <= iss_cnt_q + CW'(1);
				end
				if (vld_s1) begin
					rcv_cnt_q <= rcv_cnt_q + CW'(1);
				end
			end
		end
	end

	// Scan window and scan result.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			win_q[0] <= rdata_s1;
			for (int k = 1; k < MAX_PATTERN; k++) begin
				win_q[k] <= win_q[k - 1];
			end
		end
		if (cmd.scan_close) begin
			found_q <= hit;
			skip_q  <= hit ? (rcv_cnt_q - CW'(plen_q)) : (held_q - CW'(tail_len));
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.write_item) begin
			out_status_q <= full ? ST_FULL : ST_STORED;
			out_pos_q    <= POS_W'(rd_ptr_q);
			out_fill_q   <= full ? FILL_W'(held_q) : FILL_W'(held_q + CW'(1));
		end else if (cmd.bad_item) begin
			out_status_q <= ST_BAD_LEN;
			out_pos_q    <= POS_W'(rd_ptr_q);
			out_fill_q   <= FILL_W'(held_q);
		end else if (cmd.commit) begin
			out_status_q <= found_q ? ST_FOUND : ST_NOT_FOUND;
			out_pos_q    <= POS_W'(new_rd);
			out_fill_q   <= FILL_W'(new_held);
		end
	end

	assign status        = out_status_q;
	assign read_position = out_pos_q;
	assign fill_count    = out_fill_q;

	// The read pointer plus the held count always lands on the write pointer.
	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q == AW'(rd_ptr_q + held_q[AW-1:0]))
		else $error("ring pointers and held count disagree");

	// The held count never exceeds the ring depth.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(BUFFER_DEPTH))
		else $error("held count above ring depth");

	// Bytes reach the window only after their read was issued.
	a_rcv_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_cnt_q <= iss_cnt_q)
		else $error("window received more bytes than were read");

endmodule

>>> rtl/byte_ring_sync_search.sv
// Top level of the byte ring sync search block: stream ports, configuration
// port, controller and datapath.
// Depends on brs_pkg, brs_ctrl and brs_dpath.
//
// Sequencing: a write or a bad-length sync transaction loads its result at the
// accepting edge; with m_tready high the next one can be accepted in the next
// cycle. A sync search streams the held bytes (up to the end of the first match,
// or every held byte) through the registered store read into the window, closes
// the scan and loads its result in the commit state; new input waits for idle.
// Reset clears pointers, held count, output valid and configuration registers, not the store.
module byte_ring_sync_search
	import brs_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int MAX_PATTERN  = DEF_MAX_PATTERN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream. s_tdata: data_byte[7:0]. s_tuser: mode[0].
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,
	input  logic                  s_tuser,
	// Result stream. m_tdata: read_position[7:0], fill_count[16:8], zeros
	// [23:17]. m_tuser: status[2:0].
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0]   m_tuser,
	// Configuration write channel. Index 0 is the sync pattern, index 1 the
	// pattern length.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PATTERN_W-1:0]  cfg_data
);

	brs_cmd_t          cmd;
	brs_stat_t         stat;
	logic [POS_W-1:0]  read_position;
	logic [FILL_W-1:0] fill_count;

	// Configuration writes are always accepted. The user must issue them only
	// while the block is idle, so no scan sees a register change; the block does not enforce it.
	assign cfg_ready = 1'b1;

	// The controller decides what each accepted transaction does and when
	// the output register holds a result.
	brs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the ring, streams it through the pattern window
	// during a sync search, and registers the result fields.
	brs_dpath #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.MAX_PATTERN  (MAX_PATTERN)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_byte     (s_tdata),
		.cmd           (cmd),
		.stat          (stat),
		.status        (m_tuser),
		.read_position (read_position),
		.fill_count    (fill_count)
	);

	assign m_tdata = {(OUT_DATA_W - POS_W - FILL_W)'(0), fill_count, read_position};

endmodule

>>> test/tb.sv
// Self-checking testbench for byte_ring_sync_search: random and directed byte streams,
// sync searches and pattern settings, checked against a behavioral ring tracker.
// Depends on brs_pkg and the byte_ring_sync_search RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brs_pkg::*;

	localparam int RING_DEPTH    = DEF_BUFFER_DEPTH;
	localparam int PATTERN_MAX   = DEF_MAX_PATTERN;
	// Longest correct quiet stretch is a full-ring scan plus the
	// longest receiver stall and sender gap; this allows several times that.
	localparam int QUIET_LIMIT   = 4000;
	localparam int REPORT_MAX    = 10;

	// One result transaction as the block should present it.
	typedef struct {
		status_t     status;
		logic [7:0]  rpos;
		logic [8:0]  fill;
	} ring_result_t;

	// Tracks the ring contents, pointers and registers, and holds the results
	// that accepted items still owe.
	class ring_tracker;
		logic [7:0]      stored [RING_DEPTH];
		logic [7:0]      rd_ptr;
		logic [7:0]      wr_ptr;
		logic [8:0]      held;
		logic [63:0]     pattern;
		logic [3:0]      plen;
		ring_result_t    pending_results [$];
		int              failures;

		function new();
			rd_ptr   = '0;
			wr_ptr   = '0;
			held     = '0;
			pattern  = PATTERN_RESET;
			plen     = LENGTH_RESET;
			failures = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
			if (idx == REG_SYNC_PATTERN)
				pattern = value;
			else
				plen = value[3:0];
		endfunction

		// Scan the held bytes from the read pointer for the pattern. A full hit
		// or a pattern prefix that runs into the tail keeps the bytes from there
		// on; otherwise the ring is emptied. A bad length leaves the ring as it is.
		function status_t hunt_pattern();
			int unsigned i;
			int unsigned j;
			int unsigned avail;
			int unsigned lim;
			if (plen < 1 || plen > PATTERN_MAX)
				return ST_BAD_LEN;
			for (i = 0; i < held; i++) begin
				avail = held - i;
				lim = (avail < plen) ? avail : plen;
				for (j = 0; j < lim; j++) begin
					if (stored[(rd_ptr + i + j) % RING_DEPTH] != pattern[8*j +: 8])
						break;
				end
				if (j == plen || j == avail) begin
					rd_ptr = rd_ptr + 8'(i);
					held   = 9'(avail);
					return (j == plen) ? ST_FOUND : ST_NOT_FOUND;
				end
			end
			rd_ptr = wr_ptr;
			held   = '0;
			return ST_NOT_FOUND;
		endfunction

		function void note_item(logic mode, logic [7:0] value);
			ring_result_t res;
			if (mode == MODE_WRITE) begin
				if (held >= RING_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					stored[wr_ptr] = value;
					wr_ptr         = wr_ptr + 8'd1;
					held           = held + 9'd1;
					res.status     = ST_STORED;
				end
			end else begin
				res.status = hunt_pattern();
			end
			res.rpos = rd_ptr;
			res.fill = held;
			pending_results.push_back(res);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= REPORT_MAX)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] data);
			ring_result_t want;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: status %0d pos %0d fill %0d",
					st, data[7:0], data[16:8]));
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status || data[7:0] !== want.rpos ||
					data[16:8] !== want.fill || data[23:17] !== '0)
				note_failure($sformatf({"mismatch: expected status %0d pos %0d fill %0d, ",
					"got status %0d pos %0d fill %0d pad %h"}, want.status, want.rpos,
					want.fill, st, data[7:0], data[16:8], data[23:17]));
		endfunction

		function bit busy();
			return pending_results.size() != 0;
		endfunction
	endclass

	// Every input of the block starts at a known value.
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata   = '0;
	logic                  s_tuser   = MODE_WRITE;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SYNC_PATTERN;
	logic [PATTERN_W-1:0]  cfg_data  = '0;

	ring_tracker sb = new();

	// When calm is set neither side idles; alphabet biases written bytes toward
	// the pattern bytes so that partial and overlapping hits happen often.
	bit calm     = 1'b0;
	bit alphabet = 1'b0;
	int quiet_cycles = 0;

	byte_ring_sync_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned j;
		j = $urandom_range(0, 7);
		if (alphabet && $urandom_range(0, 99) < 70)
			return sb.pattern[8*j +: 8];
		return 8'($urandom);
	endfunction

	// Offer one item and return at the edge where the transaction completes.
	// The valid line is only lowered here when a gap precedes the item, so it is
	// never lowered and raised in the same time step.
	task automatic send_item(input logic mode, input logic [7:0] value);
		int unsigned gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(mode, value);
	endtask

	// Hold off the sender until every owed result has been taken.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.busy());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only with the block idle. The length write carries random
	// upper bits, which the register ignores.
	task automatic configure(input logic [63:0] pat, input logic [3:0] len);
		logic [63:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[3:0] = len;
		wait_drained();
		repeat (2) @(posedge clk);
		write_reg(REG_SYNC_PATTERN, pat);
		write_reg(REG_PATTERN_LENGTH, len_word);
	endtask

	// Streams of noise, whole patterns, truncated patterns at the tail and
	// patterns with a corrupted last byte, most of them followed by a search.
	task automatic random_frames(input int budget);
		int          sent;
		int          cut;
		int          pl;
		int          j;
		int unsigned r;
		logic [7:0]  b;
		sent = 0;
		pl = (sb.plen >= 1 && sb.plen <= PATTERN_MAX) ? sb.plen : $urandom_range(1, 8);
		while (sent < budget) begin
			repeat ($urandom_range(0, 5)) begin
				send_item(MODE_WRITE, pick_byte());
				sent++;
			end
			r = $urandom_range(0, 99);
			cut = pl;
			if (r >= 50 && r < 70 && pl > 1)
				cut = $urandom_range(1, pl - 1);
			if (r < 85) begin
				for (j = 0; j < cut; j++) begin
					b = sb.pattern[8*j +: 8];
					if (r >= 70 && j == cut - 1)
						b = b ^ 8'(1 << $urandom_range(0, 7));
					send_item(MODE_WRITE, b);
					sent++;
				end
			end
			// A truncated pattern is always searched so that it sits at the tail.
			if ((r >= 50 && r < 70) || $urandom_range(0, 9) < 7) begin
				send_item(MODE_SYNC, 8'($urandom));
				sent++;
			end
			if ($urandom_range(0, 99) < 4)
				wait_drained();
		end
	endtask

	// Result side: runs of ready broken by random stalls, none while calm.
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Results are sampled at the edge with the values that stood before it.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// Ends the run if no transaction of any kind completes for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int          ph;
		int unsigned r;
		logic [63:0] pat;
		logic [3:0]  len;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset pattern 05 64 of length two.
		// A search of the empty ring finds nothing and leaves it empty.
		send_item(MODE_SYNC, 8'h00);
		// A lone first pattern byte at the tail is kept as a partial hit.
		send_item(MODE_WRITE, 8'hAA);
		send_item(MODE_WRITE, 8'h05);
		send_item(MODE_SYNC, 8'hFF);
		// Completing it gives a full hit at the read pointer.
		send_item(MODE_WRITE, 8'h64);
		send_item(MODE_SYNC, 8'h00);
		send_item(MODE_WRITE, 8'h00);
		send_item(MODE_WRITE, 8'hFF);
		send_item(MODE_WRITE, 8'h05);
		send_item(MODE_SYNC, 8'h5A);

		// A one-byte pattern absent from the ring empties it.
		configure(64'h8080_8080_8080_8080, 4'd1);
		send_item(MODE_SYNC, 8'hA5);

		// Pattern lengths outside one to eight are refused.
		configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
		send_item(MODE_WRITE, 8'hFF);
		send_item(MODE_SYNC, 8'h00);
		configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
		send_item(MODE_SYNC, 8'h00);
		configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		send_item(MODE_SYNC, 8'h00);

		// Longest pattern, all ones, preceded by one stray zero byte.
		configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_item(MODE_WRITE, 8'h00);
		repeat (8) send_item(MODE_WRITE, 8'hFF);
		send_item(MODE_SYNC, 8'h00);

		// Random phases, each under its own pattern setting. Phase five fills the
		// ring past capacity so that bytes are dropped and pointers wrap.
		for (ph = 0; ph < 14; ph++) begin
			calm = (ph % 4 == 3);
			alphabet = $urandom_range(0, 1);
			r = $urandom_range(0, 9);
			case (ph)
				0: begin
					pat = '1;
					len = 4'd8;
				end
				1: begin
					pat = '0;
					len = 4'd1;
				end
				2: begin
					// Self-overlapping pattern to exercise prefix restarts.
					pat = {$urandom, 32'h5AA5_A5A5};
					len = 4'd6;
					alphabet = 1'b1;
				end
				default: begin
					pat = {$urandom, $urandom};
					if (r == 0)
						len = 4'd1;
					else if (r == 1)
						len = 4'd8;
					else if (r == 2)
						len = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
					else
						len = 4'($urandom_range(1, 8));
				end
			endcase
			configure(pat, len);
			if (ph == 5) begin
				repeat (RING_DEPTH + 6) send_item(MODE_WRITE, pick_byte());
				send_item(MODE_SYNC, 8'($urandom));
			end
			random_frames(45);
		end

		// Wait out every owed result, then a short tail for stray transactions.
		calm = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.busy())
			sb.note_failure("results still owed at the end of the run");
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
